@@ hdl/ffhp_pkg.sv @@
// Shared types, codes and constants of the first-fit heap block.
package ffhp_pkg;

  localparam int MEM_BYTES_DEF  = 65536;
  localparam int HEAP_BASE_DEF  = 32768;
  localparam int HEAP_BYTES_DEF = 16384;

  localparam logic [15:0] BLK_MAGIC = 16'hABCD;
  localparam logic [7:0]  P_READ    = 8'h01;
  localparam logic [7:0]  P_WRITE   = 8'h02;
  localparam logic [7:0]  P_ALL     = 8'h07;
  localparam int          WALK_CAP  = 8192;

  localparam logic [2:0] ACT_READ    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_ALLOC   = 3'd2;
  localparam logic [2:0] ACT_FREE    = 3'd3;
  localparam logic [2:0] ACT_PROTECT = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_SEGV    = 3'd2;
  localparam logic [2:0] ST_PROT    = 3'd3;
  localparam logic [2:0] ST_NOMEM   = 3'd4;

  // memory port base address select
  localparam logic [1:0] BASE_BA   = 2'd0;
  localparam logic [1:0] BASE_ADDR = 2'd1;
  localparam logic [1:0] BASE_NB   = 2'd2;

  // write buffer load select
  localparam logic [1:0] WB_FREE  = 2'd0;
  localparam logic [1:0] WB_PROT  = 2'd1;
  localparam logic [1:0] WB_ALLOC = 2'd2;
  localparam logic [1:0] WB_DATA  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [15:0] length;
    logic [31:0] write_data;
    logic [7:0]  protect_flags;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [15:0] alloc_address;
  } out_t;

  typedef struct packed {
    logic       ld_in;
    logic       clr_run;
    logic       walk_init;
    logic       walk_step;
    logic       rec0;
    logic       rec1;
    logic       rd_en;
    logic       wr_en;
    logic [1:0] base_sel;
    logic [2:0] idx;
    logic       rbuf_clr;
    logic       ld_wbuf;
    logic [1:0] wb_sel;
    logic       out_ld;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [2:0] action;
    logic [2:0] len3;
    logic       len_ok;
    logic       oob;
    logic       a_in_heap;
    logic       l_in_heap;
    logic       alloc_big;
    logic       walk_live;
    logic       magic_ok;
    logic       hit0;
    logic       hit1;
    logic       found0;
    logic       found1;
    logic       last;
    logic       fit;
    logic       split;
    logic       same_blk;
    logic       b0_free;
    logic       perm_ok;
    logic       hdr_free;
    logic       aaddr_zero;
  } sts_t;

endpackage

@@ hdl/first_fit_heap_with_protection_top.sv @@
// Top level of the first-fit heap with per-block protection.
//
// A byte memory of MEM_BYTES bytes holding a first-fit heap of HEAP_BYTES
// bytes at HEAP_BASE; each transaction in is one read, write, allocate,
// free or protect, and yields exactly one transaction out. After reset the
// block sweeps the whole memory, one byte per cycle, to write zeros and
// the initial free header; it takes no transaction until then. One item is
// handled at a time. The memory has one byte port with a registered read,
// so visiting one block header takes a check, eight byte reads, a capture of
// the last byte read and an evaluate. An item walks the headers, then does
// a data read or write or a header update, plus a write of a new header
// when an allocation splits a block, and last hands the result to the
// output register. Accesses outside the heap skip the walk. A finished
// result waits in the output register while the next transaction is taken
// in.
module first_fit_heap_with_protection_top #(
  parameter int MEM_BYTES  = ffhp_pkg::MEM_BYTES_DEF,
  parameter int HEAP_BASE  = ffhp_pkg::HEAP_BASE_DEF,
  parameter int HEAP_BYTES = ffhp_pkg::HEAP_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ffhp_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output ffhp_pkg::out_t out_item
);

  ffhp_pkg::cmd_t cmd;
  ffhp_pkg::sts_t sts;

  ffhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffhp_dp #(
    .MEM_BYTES  (MEM_BYTES),
    .HEAP_BASE  (HEAP_BASE),
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // an accepted transaction makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a transaction");

  // a nonzero allocation address only comes with an ok status
  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.alloc_address != 16'h0) |-> out_item.status == ffhp_pkg::ST_OK)
    else $error("allocation address reported with a fault");

  // read data is zero on any fault
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.read_data != 32'h0) |-> out_item.status == ffhp_pkg::ST_OK)
    else $error("read data reported with a fault");

endmodule

@@ hdl/ffhp_dp.sv @@
// Datapath: byte memory, header buffers, chain walk registers, result register.
module ffhp_dp #(
  parameter int MEM_BYTES  = ffhp_pkg::MEM_BYTES_DEF,
  parameter int HEAP_BASE  = ffhp_pkg::HEAP_BASE_DEF,
  parameter int HEAP_BYTES = ffhp_pkg::HEAP_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ffhp_pkg::in_t   in_item,
  input  ffhp_pkg::cmd_t  cmd,
  output ffhp_pkg::sts_t  sts,
  output ffhp_pkg::out_t  out_item
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int NW = $clog2(ffhp_pkg::WALK_CAP) + 1;
  localparam logic [16:0] MEM_LIM  = 17'(MEM_BYTES);
  localparam logic [16:0] HEAP_END = 17'(HEAP_BASE + HEAP_BYTES);
  localparam logic [16:0] HB17     = 17'(HEAP_BASE);
  localparam logic [15:0] HB16     = 16'(HEAP_BASE);
  localparam logic [63:0] INIT_HDR = {16'h0000, ffhp_pkg::P_ALL, 8'h01,
                                      16'(HEAP_BYTES), ffhp_pkg::BLK_MAGIC};

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q;

  // latched item
  logic [2:0]  act;
  logic [15:0] addr;
  logic [15:0] len;
  logic [31:0] wdata;
  logic [7:0]  flags;

  // walk state
  logic [15:0]   ba;
  logic [NW-1:0] n;
  logic          found0;
  logic          found1;
  logic [15:0]   b0;
  logic [15:0]   b1;
  logic [7:0]    b0_flag;
  logic [7:0]    b0_prot;

  logic [63:0] rbuf;
  logic [63:0] wbuf;
  logic [63:0] nbuf;
  logic [15:0] nb;
  logic [15:0] aaddr;

  logic          rd_v_q;
  logic [2:0]    rd_idx_q;
  logic          rd_oob_q;
  logic [AW:0]   clr_cnt;
  logic          clr_done;

  logic [15:0] magic, bsize, hnext;
  logic [7:0]  hflag, hprot;
  logic [15:0] lastaddr, dstart, dend;
  logic [15:0] req8;
  logic [16:0] rounded;
  logic [16:0] total;
  logic [15:0] total16;
  logic [7:0]  need;
  logic [16:0] base17;
  logic [16:0] a17;
  logic        a_ok;
  logic [16:0] clr17;
  logic [16:0] clr_off;
  logic        clr_in_hdr;
  logic [7:0]  clr_byte;
  logic [7:0]  wbyte;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]  mem_wd;

  assign magic = rbuf[15:0];
  assign bsize = rbuf[31:16];
  assign hflag = rbuf[39:32];
  assign hprot = rbuf[47:40];
  assign hnext = rbuf[63:48];

  assign lastaddr = addr + len - 16'd1;
  assign dstart   = ba + 16'd8;
  assign dend     = ba + bsize;
  assign req8     = (len < 16'd8) ? 16'd8 : len;
  assign rounded  = (17'(req8) + 17'd3) & ~17'd3;
  assign total    = rounded + 17'd8;
  assign total16  = total[15:0];
  assign need     = (act == ffhp_pkg::ACT_READ) ? ffhp_pkg::P_READ : ffhp_pkg::P_WRITE;

  always_comb begin
    unique case (cmd.base_sel)
      ffhp_pkg::BASE_ADDR: base17 = {1'b0, addr};
      ffhp_pkg::BASE_NB:   base17 = {1'b0, nb};
      default:             base17 = {1'b0, ba};
    endcase
  end

  assign a17   = base17 + 17'(cmd.idx);
  assign a_ok  = a17 < MEM_LIM;
  assign wbyte = (cmd.base_sel == ffhp_pkg::BASE_NB) ? nbuf[{cmd.idx, 3'b000} +: 8]
                                                     : wbuf[{cmd.idx, 3'b000} +: 8];

  // reset sweep: zeros, plus the initial free header
  assign clr_done   = clr_cnt == (AW+1)'(MEM_BYTES);
  assign clr17      = 17'(clr_cnt);
  assign clr_off    = clr17 - HB17;
  assign clr_in_hdr = (clr17 >= HB17) && (clr_off < 17'd8);
  assign clr_byte   = clr_in_hdr ? INIT_HDR[{clr_off[2:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    if (cmd.clr_run) begin
      mem_we = !clr_done;
      mem_wa = clr_cnt[AW-1:0];
      mem_wd = clr_byte;
    end else begin
      mem_we = cmd.wr_en && a_ok;
      mem_wa = a17[AW-1:0];
      mem_wd = wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[a17[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      if (cmd.clr_run && !clr_done) begin
        clr_cnt <= clr_cnt + (AW+1)'(1);
      end
      rd_v_q <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= cmd.idx;
    rd_oob_q <= !a_ok;
    if (cmd.ld_in) begin
      act   <= in_item.action;
      addr  <= in_item.address;
      len   <= in_item.length;
      wdata <= in_item.write_data;
      flags <= in_item.protect_flags;
    end
    if (cmd.rbuf_clr) begin
      rbuf <= '0;
    end else if (rd_v_q) begin
      rbuf[{rd_idx_q, 3'b000} +: 8] <= rd_oob_q ? 8'h00 : mem_q;
    end
    if (cmd.walk_init) begin
      ba     <= HB16;
      n      <= '0;
      found0 <= 1'b0;
      found1 <= 1'b0;
    end else if (cmd.walk_step) begin
      ba <= ba + hnext;
      n  <= n + NW'(1);
    end
    if (cmd.rec0) begin
      found0  <= 1'b1;
      b0      <= ba;
      b0_flag <= hflag;
      b0_prot <= hprot;
    end
    if (cmd.rec1) begin
      found1 <= 1'b1;
      b1     <= ba;
    end
    if (cmd.ld_wbuf) begin
      unique case (cmd.wb_sel)
        ffhp_pkg::WB_FREE: wbuf <= {rbuf[63:40], 8'h01, rbuf[31:0]};
        ffhp_pkg::WB_PROT: wbuf <= {rbuf[63:48], flags, rbuf[39:0]};
        ffhp_pkg::WB_ALLOC: begin
          wbuf  <= {sts.split ? total16 : hnext, hprot, 8'h00,
                    sts.split ? total16 : bsize, magic};
          nbuf  <= {(hnext == 16'd0) ? 16'd0 : hnext - total16, ffhp_pkg::P_ALL, 8'h01,
                    bsize - total16, ffhp_pkg::BLK_MAGIC};
          nb    <= ba + total16;
          aaddr <= dstart;
        end
        default: wbuf <= {32'h0, wdata};
      endcase
    end
    if (cmd.out_ld) begin
      out_item.status        <= cmd.status;
      out_item.read_data     <= (act == ffhp_pkg::ACT_READ && cmd.status == ffhp_pkg::ST_OK)
                                ? rbuf[31:0] : 32'h0;
      out_item.alloc_address <= (act == ffhp_pkg::ACT_ALLOC && cmd.status == ffhp_pkg::ST_OK)
                                ? aaddr : 16'h0;
    end
  end

  always_comb begin
    sts.clr_done   = clr_done;
    sts.action     = act;
    sts.len3       = len[2:0];
    sts.len_ok     = (len == 16'd1) || (len == 16'd2) || (len == 16'd4);
    sts.oob        = ({1'b0, addr} + {1'b0, len}) > MEM_LIM;
    sts.a_in_heap  = ({1'b0, addr} >= HB17) && ({1'b0, addr} < HEAP_END);
    sts.l_in_heap  = ({1'b0, lastaddr} >= HB17) && ({1'b0, lastaddr} < HEAP_END);
    sts.alloc_big  = total > 17'h0FFFF;
    sts.walk_live  = (n < NW'(ffhp_pkg::WALK_CAP)) && ({1'b0, ba} < HEAP_END);
    sts.magic_ok   = magic == ffhp_pkg::BLK_MAGIC;
    sts.hit0       = (addr >= dstart) && (addr < dend);
    sts.hit1       = (lastaddr >= dstart) && (lastaddr < dend);
    sts.found0     = found0;
    sts.found1     = found1;
    sts.last       = hnext == 16'd0;
    sts.fit        = (hflag != 8'h00) && ({1'b0, bsize} >= 17'(total16));
    sts.split      = {1'b0, bsize} >= (17'(total16) + 17'd16);
    sts.same_blk   = b0 == b1;
    sts.b0_free    = b0_flag != 8'h00;
    sts.perm_ok    = (b0_prot & need) == need;
    sts.hdr_free   = hflag != 8'h00;
    sts.aaddr_zero = dstart == 16'd0;
  end

endmodule

@@ hdl/ffhp_ctrl.sv @@
// Controller: sequences the reset sweep, chain walks, reads, writes and result hand-off.
module ffhp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ffhp_pkg::sts_t  sts,
  output ffhp_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_WCHK   = 4'd3;
  localparam logic [3:0] S_HRD    = 4'd4;
  localparam logic [3:0] S_HEVAL  = 4'd5;
  localparam logic [3:0] S_ARES   = 4'd6;
  localparam logic [3:0] S_DRD    = 4'd7;
  localparam logic [3:0] S_DWR    = 4'd8;
  localparam logic [3:0] S_HWR    = 4'd9;
  localparam logic [3:0] S_NWR    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [2:0] status, status_next;
  logic       split, split_next;
  logic       out_valid_next;
  logic       access;
  logic [2:0] end_status;

  assign access   = (sts.action == ffhp_pkg::ACT_READ) || (sts.action == ffhp_pkg::ACT_WRITE);
  assign in_stall = state != S_IDLE;

  // status when the walk ends without a match
  always_comb begin
    if (access) begin
      end_status = ffhp_pkg::ST_SEGV;
    end else if (sts.action == ffhp_pkg::ACT_ALLOC) begin
      end_status = ffhp_pkg::ST_NOMEM;
    end else begin
      end_status = ffhp_pkg::ST_INVALID;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    status_next = status;
    split_next  = split;
    cmd         = '0;
    cmd.idx     = cnt[2:0];
    cmd.status  = status;
    out_valid_next = out_valid && out_stall;

    unique case (state)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.rbuf_clr = 1'b1;
        cnt_next     = 4'd0;
        status_next  = ffhp_pkg::ST_OK;
        state_next   = S_FIN;
        if (access) begin
          priority if (!sts.len_ok) begin
            status_next = ffhp_pkg::ST_INVALID;
          end else if (sts.oob) begin
            status_next = ffhp_pkg::ST_SEGV;
          end else if (!sts.a_in_heap) begin
            if (sts.action == ffhp_pkg::ACT_READ) begin
              state_next = S_DRD;
            end else begin
              cmd.ld_wbuf = 1'b1;
              cmd.wb_sel  = ffhp_pkg::WB_DATA;
              state_next  = S_DWR;
            end
          end else if (!sts.l_in_heap) begin
            status_next = ffhp_pkg::ST_SEGV;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_WCHK;
          end
        end else if (sts.action == ffhp_pkg::ACT_ALLOC) begin
          if (sts.alloc_big) begin
            status_next = ffhp_pkg::ST_NOMEM;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_WCHK;
          end
        end else if (sts.action == ffhp_pkg::ACT_FREE || sts.action == ffhp_pkg::ACT_PROTECT) begin
          if (!sts.a_in_heap) begin
            status_next = ffhp_pkg::ST_INVALID;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = S_WCHK;
          end
        end else begin
          status_next = ffhp_pkg::ST_INVALID;
        end
      end
      S_WCHK: begin
        cnt_next = 4'd0;
        if (sts.walk_live) begin
          state_next = S_HRD;
        end else begin
          status_next = end_status;
          state_next  = S_FIN;
        end
      end
      S_HRD: begin
        cmd.base_sel = ffhp_pkg::BASE_BA;
        if (cnt < 4'd8) begin
          cmd.rd_en = 1'b1;
          cnt_next  = cnt + 4'd1;
        end else begin
          state_next = S_HEVAL;
        end
      end
      S_HEVAL: begin
        cnt_next = 4'd0;
        if (!sts.magic_ok) begin
          status_next = end_status;
          state_next  = S_FIN;
        end else if (access) begin
          cmd.rec0 = sts.hit0 && !sts.found0;
          cmd.rec1 = sts.hit1 && !sts.found1;
          if ((sts.found0 || sts.hit0) && (sts.found1 || sts.hit1)) begin
            state_next = S_ARES;
          end else if (sts.last) begin
            status_next = end_status;
            state_next  = S_FIN;
          end else begin
            cmd.walk_step = 1'b1;
            state_next    = S_WCHK;
          end
        end else if (sts.action == ffhp_pkg::ACT_ALLOC && sts.fit) begin
          cmd.ld_wbuf = 1'b1;
          cmd.wb_sel  = ffhp_pkg::WB_ALLOC;
          split_next  = sts.split;
          status_next = sts.aaddr_zero ? ffhp_pkg::ST_NOMEM : ffhp_pkg::ST_OK;
          state_next  = S_HWR;
        end else if (sts.action != ffhp_pkg::ACT_ALLOC && sts.hit0) begin
          if (sts.action == ffhp_pkg::ACT_FREE) begin
            if (sts.hdr_free) begin
              status_next = ffhp_pkg::ST_INVALID;
              state_next  = S_FIN;
            end else begin
              cmd.ld_wbuf = 1'b1;
              cmd.wb_sel  = ffhp_pkg::WB_FREE;
              state_next  = S_HWR;
            end
          end else begin
            cmd.ld_wbuf = 1'b1;
            cmd.wb_sel  = ffhp_pkg::WB_PROT;
            state_next  = S_HWR;
          end
        end else if (sts.last) begin
          status_next = end_status;
          state_next  = S_FIN;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_WCHK;
        end
      end
      S_ARES: begin
        cnt_next = 4'd0;
        if (!sts.same_blk || sts.b0_free) begin
          status_next = ffhp_pkg::ST_SEGV;
          state_next  = S_FIN;
        end else if (!sts.perm_ok) begin
          status_next = ffhp_pkg::ST_PROT;
          state_next  = S_FIN;
        end else if (sts.action == ffhp_pkg::ACT_READ) begin
          // drop the header bytes left over from the walk
          cmd.rbuf_clr = 1'b1;
          state_next   = S_DRD;
        end else begin
          cmd.ld_wbuf = 1'b1;
          cmd.wb_sel  = ffhp_pkg::WB_DATA;
          state_next  = S_DWR;
        end
      end
      S_DRD: begin
        cmd.base_sel = ffhp_pkg::BASE_ADDR;
        if (cnt < {1'b0, sts.len3}) begin
          cmd.rd_en = 1'b1;
          cnt_next  = cnt + 4'd1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DWR: begin
        cmd.base_sel = ffhp_pkg::BASE_ADDR;
        cmd.wr_en    = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == {1'b0, sts.len3} - 4'd1) state_next = S_FIN;
      end
      S_HWR: begin
        cmd.base_sel = ffhp_pkg::BASE_BA;
        cmd.wr_en    = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == 4'd7) begin
          cnt_next   = 4'd0;
          state_next = (sts.action == ffhp_pkg::ACT_ALLOC && split) ? S_NWR : S_FIN;
        end
      end
      S_NWR: begin
        cmd.base_sel = ffhp_pkg::BASE_NB;
        cmd.wr_en    = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == 4'd7) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_ld     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      cnt       <= 4'd0;
      status    <= ffhp_pkg::ST_OK;
      split     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      status    <= status_next;
      split     <= split_next;
    end
  end

endmodule
